>>> src/positional_list_engine_defines.svh
// assertion macros used by the list engine back end
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// same-cycle implication, checked on clk, off during rst
`define PLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off during rst
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ple_pkg.sv
package ple_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int MODE_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // wide enough for position and count + 1
  localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DUMP   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [CNT_W-1:0]          cnt_t;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_INS,
    OP_DEL,
    OP_DUMP
  } op_t;

  // classified command handed from front to back
  typedef struct packed {
    op_t                 kind;
    idx_t                idx;
    value_t              value;
    logic [STATUS_W-1:0] status;
    cnt_t                cnt;
  } cmd_t;

endpackage

>>> src/ple_if.sv
interface ple_req_if;
  import ple_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  value_t              value;
  logic [POS_W-1:0]    position;

  modport source (output valid, output mode, output value, output position, input ready);
  modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

interface ple_rsp_if;
  import ple_pkg::*;

  logic                valid;
  logic                ready;
  value_t              element;
  logic                element_valid;
  logic                last;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, output element, output element_valid, output last,
                  output status, output entry_count, input ready);
  modport sink   (input valid, input element, input element_valid, input last,
                  input status, input entry_count, output ready);
endinterface

>>> src/ple_front.sv
module ple_front (
  input  logic          clk,
  input  logic          rst,
  ple_req_if.sink       req,
  output logic          push_valid,
  input  logic          push_ready,
  output ple_pkg::cmd_t push_cmd
);
  import ple_pkg::*;

  // count as it will stand once every queued command has run
  cnt_t             cnt;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic [POS_W-1:0] pos_m1;
  logic             pos_zero;
  logic             full;

  always_comb begin
    pos_ext  = CMP_W'(req.position);
    cnt_ext  = CMP_W'(cnt);
    pos_m1   = req.position - POS_W'(1);
    pos_zero = (req.position == '0);
    full     = (cnt == CNT_W'(CAPACITY));

    push_cmd.kind   = OP_NOP;
    push_cmd.idx    = pos_m1[IDX_W-1:0];
    push_cmd.value  = req.value;
    push_cmd.status = ST_OK;
    push_cmd.cnt    = cnt;

    case (req.mode)
      MODE_INSERT: begin
        if (pos_zero || pos_ext > cnt_ext + CMP_W'(1)) begin
          push_cmd.status = ST_RANGE;
        end else if (full) begin
          push_cmd.status = ST_FULL;
        end else begin
          push_cmd.kind = OP_INS;
          push_cmd.cnt  = cnt + CNT_W'(1);
        end
      end
      MODE_DELETE: begin
        if (pos_zero || pos_ext > cnt_ext) begin
          push_cmd.status = ST_RANGE;
        end else begin
          push_cmd.kind = OP_DEL;
          push_cmd.cnt  = cnt - CNT_W'(1);
        end
      end
      MODE_DUMP: begin
        // empty list dumps as one bare result
        if (cnt != '0) begin
          push_cmd.kind = OP_DUMP;
        end
      end
      default: begin
        push_cmd.kind = OP_NOP;
      end
    endcase
  end

  assign push_valid = req.valid;
  assign req.ready  = push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (req.valid && push_ready) begin
      cnt <= push_cmd.cnt;
    end
  end

endmodule

>>> src/ple_queue.sv
module ple_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  ple_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output ple_pkg::cmd_t pop_cmd
);
  import ple_pkg::*;

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              push;
  logic              pop;

  assign push_ready = (fill != QCNT_W'(QDEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

>>> src/ple_back.sv
`include "positional_list_engine_defines.svh"

module ple_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  ple_pkg::cmd_t pop_cmd,
  ple_rsp_if.source     rsp
);
  import ple_pkg::*;

  value_t              slots [CAPACITY];
  logic                dumping;
  idx_t                dump_ptr;
  cnt_t                dump_cnt;
  logic                dump_last;
  logic                out_free;
  logic                pop;
  logic                out_valid;
  value_t              out_element;
  logic                out_ev;
  logic                out_last;
  logic [STATUS_W-1:0] out_status;
  cnt_t                out_cnt;

  assign out_free  = !out_valid || rsp.ready;
  assign pop_ready = out_free && !dumping;
  assign pop       = pop_valid && pop_ready;
  assign dump_last = (CNT_W'(dump_ptr) + CNT_W'(1) == dump_cnt);

  // list storage: the slots from the index up shift at once
  for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
    always_ff @(posedge clk) begin
      if (pop && pop_cmd.kind == OP_INS) begin
        if (IDX_W'(g) == pop_cmd.idx) begin
          slots[g] <= pop_cmd.value;
        end else if (IDX_W'(g) > pop_cmd.idx) begin
          slots[g] <= slots[(g > 0) ? g - 1 : 0];
        end
      end else if (pop && pop_cmd.kind == OP_DEL) begin
        if (IDX_W'(g) >= pop_cmd.idx) begin
          slots[g] <= slots[(g < CAPACITY - 1) ? g + 1 : g];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      dumping   <= 1'b0;
    end else if (dumping && out_free) begin
      out_valid <= 1'b1;
      dumping   <= !dump_last;
    end else if (pop) begin
      out_valid <= 1'b1;
      dumping   <= (pop_cmd.kind == OP_DUMP) && (pop_cmd.cnt != CNT_W'(1));
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dumping && out_free) begin
      out_element <= slots[dump_ptr];
      out_ev      <= 1'b1;
      out_last    <= dump_last;
      out_status  <= ST_OK;
      out_cnt     <= dump_cnt;
      dump_ptr    <= dump_ptr + IDX_W'(1);
    end else if (pop) begin
      out_status <= pop_cmd.status;
      out_cnt    <= pop_cmd.cnt;
      if (pop_cmd.kind == OP_DUMP) begin
        out_element <= slots[0];
        out_ev      <= 1'b1;
        out_last    <= (pop_cmd.cnt == CNT_W'(1));
        dump_ptr    <= IDX_W'(1);
        dump_cnt    <= pop_cmd.cnt;
      end else begin
        out_element <= '0;
        out_ev      <= 1'b0;
        out_last    <= 1'b1;
      end
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.element       = out_element;
  assign rsp.element_valid = out_ev;
  assign rsp.last          = out_last;
  assign rsp.status        = out_status;
  assign rsp.entry_count   = COUNT_W'(out_cnt);

  `PLE_ASSERT_NOW(a_dump_ptr_in_range, dumping, CNT_W'(dump_ptr) < dump_cnt, "dump pointer past count")
  `PLE_ASSERT_NOW(a_open_dump, out_valid && !out_last, dumping && out_ev, "non-final result outside a dump")
  `PLE_ASSERT_NOW(a_bare_zero, out_valid && !out_ev, out_element == '0 && out_last, "bare result not zero and final")
  `PLE_ASSERT_NEXT(a_single_result, pop && pop_cmd.kind != OP_DUMP, out_valid && out_last && !out_ev && !dumping, "insert or delete gave no single final result")

endmodule

>>> src/positional_list_engine.sv
// an accepted request is written into the command queue; the back end takes it from there
//   and registers its result in its output register, from which the result is shown
// the back end gives one result for an insert, a delete or a bare request and one per
//   stored entry for a dump, paced by the output register, and takes no new command during a dump
// the front end takes a new request each cycle while the two-entry command queue has room
// reset (synchronous, rst high): entry count zero, queue and output empty;
//   list contents are not cleared and hold no meaning until written
module positional_list_engine (
  input  logic      clk,
  input  logic      rst,
  ple_req_if.sink   req,
  ple_rsp_if.source rsp
);
  import ple_pkg::*;

  // front to queue
  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;

  // queue to back
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  // front end: range and full checks against its own running count,
  // so classification never waits on the back end
  ple_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // short command queue, lets a dump in the back end run while requests keep arriving
  ple_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // back end: shifting slot array plus registered result stage;
  // insert/delete shift slots from the index up; a dump walks one a cycle unless stalled
  ple_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .rsp       (rsp)
  );

endmodule

>>> verif/tb_positional_list_engine.sv
`timescale 1ns / 1ps

module tb_positional_list_engine;
  import ple_pkg::*;

  // one request as the sender sees it
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    value_t            value;
    logic [POS_W-1:0]  position;
  } list_op_t;

  // one result word as the block should show it
  typedef struct packed {
    value_t              element;
    logic                element_valid;
    logic                last;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;
  } list_result_t;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_OPS  = 400;
  localparam int DRAIN_WAIT  = 20;
  // no idling on either side inside this window of cycles
  localparam int CALM_FROM   = 1500;
  localparam int CALM_TO     = 2700;
  localparam int IDLE_PCT    = 19;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  logic clk;
  logic rst;

  ple_req_if req_ch ();
  ple_rsp_if rsp_ch ();

  positional_list_engine dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // requests waiting to be offered, and the one currently on the bus
  list_op_t     op_queue[$];
  list_op_t     held_op;
  // shadow of the list contents, front of the queue is position 1
  value_t       list_shadow[$];
  // results still owed by the block, oldest first
  list_result_t owed_results[$];

  int ops_total;
  int ops_accepted;
  int mismatches;
  int cycle_count;
  int gen_count;
  logic calm;

  assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

  // queue a request and track how the list length will move, so the
  // generator can aim positions at the live range
  task automatic queue_op(input logic [MODE_W-1:0] mode, input value_t value,
                          input logic [POS_W-1:0] position);
    list_op_t op;
    op.mode     = mode;
    op.value    = value;
    op.position = position;
    op_queue.push_back(op);
    ops_total++;
    if (mode == MODE_INSERT && position >= 1 && position <= gen_count + 1
        && gen_count < CAPACITY)
      gen_count++;
    else if (mode == MODE_DELETE && position >= 1 && position <= gen_count)
      gen_count--;
  endtask

  function automatic list_result_t make_result(input value_t element, input logic ev,
                                               input logic last,
                                               input logic [STATUS_W-1:0] status);
    list_result_t res;
    res.element       = element;
    res.element_valid = ev;
    res.last          = last;
    res.status        = status;
    res.entry_count   = COUNT_W'(list_shadow.size());
    return res;
  endfunction

  // apply one accepted request to the shadow list and note the results it owes
  task automatic apply_list_op(input list_op_t op);
    int                  n;
    int                  pos;
    logic [STATUS_W-1:0] st;
    n   = list_shadow.size();
    pos = int'(op.position);
    st  = ST_OK;
    if (op.mode == MODE_DUMP) begin
      if (n == 0) begin
        owed_results.push_back(make_result('0, 1'b0, 1'b1, ST_OK));
      end else begin
        for (int i = 0; i < n; i++)
          owed_results.push_back(make_result(list_shadow[i], 1'b1, i == n - 1, ST_OK));
      end
    end else begin
      if (op.mode == MODE_INSERT) begin
        // range is checked before fullness
        if (pos < 1 || pos > n + 1) st = ST_RANGE;
        else if (n >= CAPACITY) st = ST_FULL;
        else list_shadow.insert(pos - 1, op.value);
      end else if (op.mode == MODE_DELETE) begin
        if (pos < 1 || pos > n) st = ST_RANGE;
        else list_shadow.delete(pos - 1);
      end
      // the spare mode falls through with status ok and no change
      owed_results.push_back(make_result('0, 1'b0, 1'b1, st));
    end
  endtask

  // request driver: offers the next queued request, idling now and then
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        apply_list_op(held_op);
        ops_accepted++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (op_queue.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          held_op = op_queue.pop_front();
          req_ch.valid    <= 1'b1;
          req_ch.mode     <= held_op.mode;
          req_ch.value    <= held_op.value;
          req_ch.position <= held_op.position;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: random back-pressure, each accepted result checked
  // against the oldest one owed
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (owed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: element %0d ev %0b last %0b status %0d count %0d",
                     rsp_ch.element, rsp_ch.element_valid, rsp_ch.last,
                     rsp_ch.status, rsp_ch.entry_count);
        end else begin
          list_result_t want;
          want = owed_results.pop_front();
          if (rsp_ch.element !== want.element || rsp_ch.element_valid !== want.element_valid
              || rsp_ch.last !== want.last || rsp_ch.status !== want.status
              || rsp_ch.entry_count !== want.entry_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp element %0d ev %0b last %0b status %0d count %0d,",
                        " got element %0d ev %0b last %0b status %0d count %0d"},
                       want.element, want.element_valid, want.last, want.status,
                       want.entry_count, rsp_ch.element, rsp_ch.element_valid,
                       rsp_ch.last, rsp_ch.status, rsp_ch.entry_count);
          end
        end
      end
      rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst) cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** positional_list_engine: FAILED **");
      $finish;
    end
  end

  initial begin
    int   pick;
    logic filling;

    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.mode     = MODE_INSERT;
    req_ch.value    = '0;
    req_ch.position = '0;
    rsp_ch.ready    = 1'b0;
    ops_total       = 0;
    ops_accepted    = 0;
    mismatches      = 0;
    cycle_count     = 0;
    gen_count       = 0;

    // directed: empty-list corners, extreme values, ends and middle, bad positions
    queue_op(MODE_DUMP,   $urandom, 8'd0);             // dump of an empty list
    queue_op(MODE_DELETE, $urandom, 8'd1);             // delete from empty list
    queue_op(MODE_INSERT, $urandom, 8'd0);             // position zero
    queue_op(MODE_INSERT, $urandom, 8'd2);             // past count + 1
    queue_op(MODE_INSERT, 32'sh8000_0000, 8'd1);       // most negative value
    queue_op(MODE_INSERT, 32'sh7FFF_FFFF, 8'd2);       // append, most positive value
    queue_op(MODE_INSERT, -32'sd1, 8'd1);              // at the front
    queue_op(MODE_INSERT, 32'sd0, 8'd2);               // in the middle
    queue_op(MODE_DUMP,   32'sh5A5A_A5A5, 8'hFF);
    queue_op(MODE_SPARE,  32'shFFFF_FFFF, 8'hFF);      // unused mode
    queue_op(MODE_DELETE, $urandom, 8'd0);             // delete at position zero
    queue_op(MODE_DELETE, $urandom, 8'd5);             // delete past count
    queue_op(MODE_INSERT, $urandom, 8'd255);           // widest position
    queue_op(MODE_DELETE, $urandom, 8'd2);             // delete in the middle
    queue_op(MODE_DELETE, $urandom, 8'd3);             // delete the last entry
    queue_op(MODE_DELETE, $urandom, 8'd1);             // delete the first entry
    queue_op(MODE_DUMP,   $urandom, 8'h00);
    queue_op(MODE_DELETE, $urandom, 8'd1);             // back to empty
    queue_op(MODE_DUMP,   $urandom, 8'hAA);

    // random: sweep the list between empty and full so that full-list
    // refusals and long dumps come up many times
    filling = 1'b1;
    for (int k = 0; k < RANDOM_OPS; k++) begin
      if (filling && gen_count == CAPACITY && $urandom_range(0, 3) == 0) filling = 1'b0;
      else if (!filling && gen_count == 0) filling = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 4)
        queue_op(MODE_SPARE, $urandom, POS_W'($urandom_range(0, 255)));
      else if (pick < 12)
        // noise: any position, often out of range
        queue_op(MODE_W'($urandom_range(0, 1)), $urandom, POS_W'($urandom_range(0, 255)));
      else if (pick < 26)
        queue_op(MODE_DUMP, $urandom, POS_W'($urandom_range(0, 255)));
      else if (pick < (filling ? 80 : 40))
        queue_op(MODE_INSERT, $urandom, POS_W'($urandom_range(1, gen_count + 1)));
      else if (gen_count > 0)
        queue_op(MODE_DELETE, $urandom, POS_W'($urandom_range(1, gen_count)));
      else
        queue_op(MODE_INSERT, $urandom, 8'd1);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // every request accepted, every owed result seen, then a short quiet spell
    // to catch anything extra; the watchdog bounds both waits
    while (ops_accepted != ops_total) @(negedge clk);
    while (owed_results.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (mismatches == 0 && owed_results.size() == 0)
      $display("** positional_list_engine: PASSED **");
    else
      $display("** positional_list_engine: FAILED **");
    $finish;
  end

endmodule
